// File: hdl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Input and output field widths.
  localparam int unsigned HueW  = 16;
  localparam int unsigned FracW = 17;
  localparam int unsigned ChanW = 8;

  // Internal datapath widths.
  localparam int unsigned GpW   = 13;  // hue factor, 0..7680
  localparam int unsigned SvW   = 33;  // S*V, at most 2^32
  localparam int unsigned VkW   = 29;  // V*7680
  localparam int unsigned ProdW = 45;  // S*V*factor and V*7680*2^16

  // Input limits.
  localparam logic [HueW-1:0]  HUE_MAX  = 16'd46079;
  localparam logic [FracW-1:0] UNIT_ONE = 17'd65536;

  // One sextant of hue (60 degrees) and the sextant starts.
  localparam logic [GpW-1:0]  HUE_SEXTANT = 13'd7680;
  localparam logic [HueW-1:0] HUE_60      = 16'd7680;
  localparam logic [HueW-1:0] HUE_120     = 16'd15360;
  localparam logic [HueW-1:0] HUE_180     = 16'd23040;
  localparam logic [HueW-1:0] HUE_240     = 16'd30720;
  localparam logic [HueW-1:0] HUE_300     = 16'd38400;

  // Sextant codes.
  localparam logic [2:0] SEXT_RED     = 3'd0;
  localparam logic [2:0] SEXT_YELLOW  = 3'd1;
  localparam logic [2:0] SEXT_GREEN   = 3'd2;
  localparam logic [2:0] SEXT_CYAN    = 3'd3;
  localparam logic [2:0] SEXT_BLUE    = 3'd4;
  localparam logic [2:0] SEXT_MAGENTA = 3'd5;

  // Load enables for the per-channel stages.
  typedef struct packed {
    logic en3;
    logic en4;
    logic en5;
  } lane_en_t;

endpackage

// File: hdl/hsv2rgb_lane.sv
`timescale 1ns / 1ps

// One color channel: floor(17 * (V*7680*2^16 - S*V*gp) / 2^41).
module hsv2rgb_lane import hsv2rgb_pkg::*; (
  input  logic             clk_i,
  input  lane_en_t         en_i,
  input  logic [SvW-1:0]   sv_i,
  input  logic [GpW-1:0]   gp_i,
  input  logic [VkW-1:0]   vk_i,
  output logic [ChanW-1:0] chan_o
);

  logic [ProdW:0]   prod_full;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [ProdW-1:0] diff_d, diff_q;
  logic [ProdW+3:0] scaled;
  logic [ChanW-1:0] chan_d, chan_q;

  // Stage 3: product of chroma and the hue factor.
  assign prod_full = {{(ProdW+1-SvW){1'b0}}, sv_i} * {{(ProdW+1-GpW){1'b0}}, gp_i};
  assign prod_d    = prod_full[ProdW-1:0];

  // Stage 4: remove it from the full-value term; the difference is never negative.
  assign diff_d = {vk_i, 16'b0} - prod_q;

  // Stage 5: times 17, then keep the integer part of the channel.
  assign scaled = {diff_q, 4'b0} + {4'b0, diff_q};
  assign chan_d = scaled[ProdW+3:ProdW-4];

  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      prod_q <= prod_d;
    end
    if (en_i.en4) begin
      diff_q <= diff_d;
    end
    if (en_i.en5) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

// File: hdl/hsv_to_rgb_pixel.sv
`timescale 1ns / 1ps
// HSV to 8-bit RGB conversion in a five-stage pipeline.
// Each pixel passes through the registers of stages 1 to 5 in order before it reaches the outputs.
// Throughput: one pixel per cycle; a stall holds the pipeline and fills bubbles.
// The widest step is the 33 by 13 bit chroma-times-hue multiply in each lane.
// Reset clears only the stage valid bits; the data registers are not reset.
module hsv_to_rgb_pixel import hsv2rgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [HueW-1:0]  hue_i,
  input  logic [FracW-1:0] saturation_i,
  input  logic [FracW-1:0] brightness_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  logic [5:1] valid_q;
  logic [5:1] ready;
  lane_en_t   lane_en;

  // Stage enables: a stage loads when it is empty or its successor moves.
  assign ready[5] = !valid_q[5] || !stall_i;
  assign ready[4] = !valid_q[4] || ready[5];
  assign ready[3] = !valid_q[3] || ready[4];
  assign ready[2] = !valid_q[2] || ready[3];
  assign ready[1] = !valid_q[1] || ready[2];
  assign stall_o  = !ready[1];
  assign valid_o  = valid_q[5];

  assign lane_en.en3 = ready[3];
  assign lane_en.en4 = ready[4];
  assign lane_en.en5 = ready[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[1]) valid_q[1] <= valid_i;
      if (ready[2]) valid_q[2] <= valid_q[1];
      if (ready[3]) valid_q[3] <= valid_q[2];
      if (ready[4]) valid_q[4] <= valid_q[3];
      if (ready[5]) valid_q[5] <= valid_q[4];
    end
  end

  // Stage 1: limit the inputs and find the hue sextant and offset within it.
  logic [HueW-1:0]  hue_c;
  logic [FracW-1:0] sat_c, val_c;
  logic [HueW-1:0]  base;
  logic [2:0]       sext_d, sext_q;
  logic [HueW-1:0]  frac_full;
  logic [GpW-1:0]   frac_q;
  logic [FracW-1:0] sat_q, val1_q;

  assign hue_c = (hue_i > HUE_MAX) ? HUE_MAX : hue_i;
  assign sat_c = (saturation_i > UNIT_ONE) ? UNIT_ONE : saturation_i;
  assign val_c = (brightness_i > UNIT_ONE) ? UNIT_ONE : brightness_i;

  always_comb begin
    priority if (hue_c >= HUE_300) begin
      sext_d = SEXT_MAGENTA;
      base   = HUE_300;
    end else if (hue_c >= HUE_240) begin
      sext_d = SEXT_BLUE;
      base   = HUE_240;
    end else if (hue_c >= HUE_180) begin
      sext_d = SEXT_CYAN;
      base   = HUE_180;
    end else if (hue_c >= HUE_120) begin
      sext_d = SEXT_GREEN;
      base   = HUE_120;
    end else if (hue_c >= HUE_60) begin
      sext_d = SEXT_YELLOW;
      base   = HUE_60;
    end else begin
      sext_d = SEXT_RED;
      base   = '0;
    end
  end

  assign frac_full = hue_c - base;

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      sext_q <= sext_d;
      frac_q <= frac_full[GpW-1:0];
      sat_q  <= sat_c;
      val1_q <= val_c;
    end
  end

  // Stage 2: chroma S*V and the hue factor that each channel subtracts.
  // The chroma channel subtracts nothing, the zero channel all of the chroma.
  logic [2*FracW-1:0] sv_full;
  logic [SvW-1:0]     sv_q;
  logic [GpW-1:0]     gx;
  logic [GpW-1:0]     gp_r_d, gp_g_d, gp_b_d;
  logic [GpW-1:0]     gp_r_q, gp_g_q, gp_b_q;
  logic [FracW-1:0]   val2_q;

  assign sv_full = {{FracW{1'b0}}, sat_q} * {{FracW{1'b0}}, val1_q};
  assign gx      = sext_q[0] ? frac_q : (HUE_SEXTANT - frac_q);

  always_comb begin
    unique case (sext_q)
      SEXT_RED: begin
        gp_r_d = '0;          gp_g_d = gx;          gp_b_d = HUE_SEXTANT;
      end
      SEXT_YELLOW: begin
        gp_r_d = gx;          gp_g_d = '0;          gp_b_d = HUE_SEXTANT;
      end
      SEXT_GREEN: begin
        gp_r_d = HUE_SEXTANT; gp_g_d = '0;          gp_b_d = gx;
      end
      SEXT_CYAN: begin
        gp_r_d = HUE_SEXTANT; gp_g_d = gx;          gp_b_d = '0;
      end
      SEXT_BLUE: begin
        gp_r_d = gx;          gp_g_d = HUE_SEXTANT; gp_b_d = '0;
      end
      default: begin
        gp_r_d = '0;          gp_g_d = HUE_SEXTANT; gp_b_d = gx;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ready[2]) begin
      sv_q   <= sv_full[SvW-1:0];
      gp_r_q <= gp_r_d;
      gp_g_q <= gp_g_d;
      gp_b_q <= gp_b_d;
      val2_q <= val1_q;
    end
  end

  // Stage 3: value scaled by one sextant, shared by all three lanes.
  logic [VkW-1:0] vk_d, vk_q;

  assign vk_d = {{(VkW-FracW){1'b0}}, val2_q} * {{(VkW-GpW){1'b0}}, HUE_SEXTANT};

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      vk_q <= vk_d;
    end
  end

  // Stages 3 to 5 of each channel.
  hsv2rgb_lane u_lane_r (
    .clk_i  (clk_i),
    .en_i   (lane_en),
    .sv_i   (sv_q),
    .gp_i   (gp_r_q),
    .vk_i   (vk_q),
    .chan_o (red_o)
  );

  hsv2rgb_lane u_lane_g (
    .clk_i  (clk_i),
    .en_i   (lane_en),
    .sv_i   (sv_q),
    .gp_i   (gp_g_q),
    .vk_i   (vk_q),
    .chan_o (green_o)
  );

  hsv2rgb_lane u_lane_b (
    .clk_i  (clk_i),
    .en_i   (lane_en),
    .sv_i   (sv_q),
    .gp_i   (gp_b_q),
    .vk_i   (vk_q),
    .chan_o (blue_o)
  );

endmodule

// File: dv/hsv_rgb_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the HSV to RGB converter, predicts every pixel
// that enters and compares each result leaving the block with the oldest
// pending prediction.
module hsv_rgb_checker import hsv2rgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [HueW-1:0]  hue_i,
  input  logic [FracW-1:0] saturation_i,
  input  logic [FracW-1:0] brightness_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o
);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  localparam logic [63:0] SextantLen = 64'(HUE_SEXTANT);
  localparam logic [63:0] ChanFull   = 64'd255;

  rgb_t rgb_pending_q[$];

  // One channel: floor(255 * (comp + m)) where both carry 7680 * 2^32 as denominator.
  function automatic logic [ChanW-1:0] scale_channel(logic [63:0] comp, logic [63:0] offset);
    logic [63:0] num;
    logic [63:0] lvl;
    num = (comp + offset) * ChanFull;
    lvl = num / (SextantLen << 32);
    if (lvl > ChanFull) lvl = ChanFull;
    return lvl[ChanW-1:0];
  endfunction

  // Exact integer HSV to RGB conversion with input saturation.
  function automatic rgb_t predict_rgb(logic [HueW-1:0] hue, logic [FracW-1:0] sat,
                                       logic [FracW-1:0] val);
    logic [63:0] h, s, v, sext, frac, factor, sv, c_sc, x_sc, m_sc;
    logic [63:0] cr, cg, cb;
    rgb_t res;
    h = 64'(hue);
    s = 64'(sat);
    v = 64'(val);
    if (h > 64'(HUE_MAX)) h = 64'(HUE_MAX);
    if (s > 64'(UNIT_ONE)) s = 64'(UNIT_ONE);
    if (v > 64'(UNIT_ONE)) v = 64'(UNIT_ONE);
    sext = h / SextantLen;
    frac = h % SextantLen;
    // Odd sextants run the secondary component downward.
    factor = sext[0] ? (SextantLen - frac) : frac;
    sv   = s * v;
    c_sc = sv * SextantLen;
    x_sc = sv * factor;
    m_sc = ((v << 16) * SextantLen) - c_sc;
    case (sext[2:0])
      SEXT_RED: begin
        cr = c_sc; cg = x_sc; cb = 64'd0;
      end
      SEXT_YELLOW: begin
        cr = x_sc; cg = c_sc; cb = 64'd0;
      end
      SEXT_GREEN: begin
        cr = 64'd0; cg = c_sc; cb = x_sc;
      end
      SEXT_CYAN: begin
        cr = 64'd0; cg = x_sc; cb = c_sc;
      end
      SEXT_BLUE: begin
        cr = x_sc; cg = 64'd0; cb = c_sc;
      end
      default: begin
        cr = c_sc; cg = 64'd0; cb = x_sc;
      end
    endcase
    res.red   = scale_channel(cr, m_sc);
    res.green = scale_channel(cg, m_sc);
    res.blue  = scale_channel(cb, m_sc);
    return res;
  endfunction

  // Compare each output transfer first, then queue the prediction for the input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      rgb_pending_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (rgb_pending_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                     red_i, green_i, blue_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rgb_pending_q.pop_front();
          if (want.red !== red_i || want.green !== green_i || want.blue !== blue_i) begin
            if (fail_count_o < 10)
              $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue, red_i, green_i, blue_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        rgb_pending_q.push_back(predict_rgb(hue_i, saturation_i, brightness_i));
      pending_o <= rgb_pending_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Drives HSV pixels into the converter with random idle cycles on both sides
// and reports the verdict from the checker's failure and pending counts.
module tb_top;
  import hsv2rgb_pkg::*;

  localparam int unsigned RandPixels = 1400;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainWait  = 20;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             valid_i = 1'b0;
  logic             stall_o;
  logic [HueW-1:0]  hue_i = '0;
  logic [FracW-1:0] saturation_i = '0;
  logic [FracW-1:0] brightness_i = '0;
  logic             valid_o;
  logic             stall_i = 1'b0;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned directed = 0;
  logic        quiet = 1'b0;

  always #2 clk_i = ~clk_i;

  hsv_to_rgb_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  hsv_rgb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_i),
    .in_stall_i   (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_i  (valid_o),
    .out_stall_i  (stall_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver back-pressure, switched off during the quiet stretch.
  always @(posedge clk_i) begin
    stall_i <= rst_ni && !quiet && ($urandom_range(99) < 9);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // One pixel transfer, with an optional idle gap ahead of it.
  task automatic send_pixel(logic [HueW-1:0] hue, logic [FracW-1:0] sat,
                            logic [FracW-1:0] val);
    logic taken;
    while (!quiet && $urandom_range(99) < 9) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= val;
    // Inputs only change on rising edges, so mid-cycle stall equals the edge value.
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end
    sent++;
  endtask

  // Saturation or brightness: mostly in range, with extremes and full-width noise.
  function automatic logic [FracW-1:0] rand_unit();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return FracW'($urandom_range(131071));
    if (pick == 1) return ($urandom_range(1) != 0) ? UNIT_ONE : '0;
    return FracW'($urandom_range(65536));
  endfunction

  // Hue: mostly in range, some near sextant edges, some above the limit.
  function automatic logic [HueW-1:0] rand_hue();
    int unsigned pick;
    int unsigned edge_at;
    pick = $urandom_range(9);
    if (pick == 0) return HueW'($urandom_range(65535));
    if (pick == 1) begin
      edge_at = $urandom_range(1, 5) * 7680 + $urandom_range(2) - 1;
      return HueW'(edge_at);
    end
    return HueW'($urandom_range(46079));
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: black, each sextant start, sextant edges and the clamps.
    send_pixel(16'd0, 17'd0, 17'd0);
    send_pixel(16'd0, UNIT_ONE, UNIT_ONE);
    send_pixel(HUE_60, UNIT_ONE, UNIT_ONE);
    send_pixel(HUE_120, UNIT_ONE, UNIT_ONE);
    send_pixel(HUE_180, UNIT_ONE, UNIT_ONE);
    send_pixel(HUE_240, UNIT_ONE, UNIT_ONE);
    send_pixel(HUE_300, UNIT_ONE, UNIT_ONE);
    send_pixel(HUE_MAX, UNIT_ONE, UNIT_ONE);
    send_pixel(16'd7679, UNIT_ONE, UNIT_ONE);
    send_pixel(16'd3840, UNIT_ONE, UNIT_ONE);
    send_pixel(16'd11520, 17'd32768, UNIT_ONE);
    send_pixel(16'd46080, UNIT_ONE, UNIT_ONE);
    send_pixel(16'hFFFF, 17'h1FFFF, 17'h1FFFF);
    send_pixel(16'd19200, 17'h1FFFF, 17'd40000);
    send_pixel(16'd34560, 17'd50000, 17'h1FFFF);
    send_pixel(16'd26880, 17'd0, UNIT_ONE);
    send_pixel(16'd26880, UNIT_ONE, 17'd0);
    send_pixel(16'd42240, 17'd1, 17'd1);
    send_pixel(16'd19200, 17'd65535, 17'd65535);
    send_pixel(16'd42240, 17'd32768, 17'd32768);
    send_pixel(16'd1, 17'd65536, 17'd1);
    directed = sent;

    // Random pixels, with a stretch free of idling on either side.
    for (int unsigned i = 0; i < RandPixels; i++) begin
      quiet <= (i >= 600 && i < 900);
      send_pixel(rand_hue(), rand_unit(), rand_unit());
    end
    valid_i <= 1'b0;
    quiet   <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d pixels (%0d directed: sextant edges, clamps, extremes), checked %0d.",
             sent, directed, checked);
    $display("Both sides idled at random outside a quiet stretch of 300 pixels.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d failures, %0d predictions left over", fail_count, pending);
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
